// ===== src/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// Accumulator machine package
// Opcodes, register selects, sequencer states and the control and status
// bundles passed between the execute block and its multiply/divide unit.
// ----------------------------------------------------------------------------
package ame_pkg;

  // Instruction opcodes; codes 11 to 15 are no-ops.
  typedef enum logic [3:0] {
    OP_MOV = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_MUL = 4'd3,
    OP_DIV = 4'd4,
    OP_MOD = 4'd5,
    OP_JMP = 4'd6,
    OP_JEQ = 4'd7,
    OP_JLT = 4'd8,
    OP_JGT = 4'd9,
    OP_PRT = 4'd10
  } op_t;

  // Register file selects.
  typedef enum logic [1:0] {
    REG_ACC = 2'd0,
    REG_DAT = 2'd1,
    REG_EXT = 2'd2,
    REG_PC  = 2'd3
  } reg_sel_t;

  // Execute sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_WAIT = 2'd2,
    ST_FIX  = 2'd3
  } state_t;

  // Command into the multiply/divide unit.
  typedef struct packed {
    logic start;
    logic divide;
  } md_ctl_t;

  // Status back from the multiply/divide unit.
  typedef struct packed {
    logic busy;
    logic done;
  } md_sts_t;

  // Offset reported when no jump is taken.
  localparam logic [31:0] OFFSET_NONE = 32'd1;

endpackage

// ===== src/ame_muldiv.sv =====
// ----------------------------------------------------------------------------
// Iterative multiply/divide unit
// Unsigned shift-add multiply and restoring divide, one bit per cycle over
// one shared adder.
// ----------------------------------------------------------------------------
module ame_muldiv
  import ame_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  md_ctl_t               ctl,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output md_sts_t               sts,
  output logic [DATA_WIDTH-1:0] res,
  output logic [DATA_WIDTH-1:0] quo
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic                  busy;
  logic                  done;
  logic                  divide;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH+1:0] add_x;
  logic [DATA_WIDTH+1:0] add_y;
  logic [DATA_WIDTH+1:0] sum;
  logic                  ge;

  // Shared adder: partial-product add for multiply, trial subtract for divide.
  always_comb begin
    rem_sh = {res, opa[DATA_WIDTH-1]};
    if (divide) begin
      add_x = {1'b0, rem_sh};
      add_y = ~{2'b00, opb};
    end else begin
      add_x = {2'b00, res};
      add_y = {2'b00, (opb[0] ? opa : {DATA_WIDTH{1'b0}})};
    end
    sum = add_x + add_y + {{(DATA_WIDTH+1){1'b0}}, divide};
    ge  = ~sum[DATA_WIDTH+1];
  end

  // Control: busy flag, bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operand shift registers and running result.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      divide <= ctl.divide;
      opa    <= a;
      opb    <= b;
      res    <= '0;
    end else if (busy) begin
      if (divide) begin
        res <= ge ? sum[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        opa <= {opa[DATA_WIDTH-2:0], ge};
      end else begin
        res <= sum[DATA_WIDTH-1:0];
        opa <= {opa[DATA_WIDTH-2:0], 1'b0};
        opb <= {1'b0, opb[DATA_WIDTH-1:1]};
      end
    end
  end

  assign quo      = opa;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ===== src/accumulator_machine_execute.sv =====
// ----------------------------------------------------------------------------
// Accumulator machine execute stage
// Executes one instruction per request on the acc, dat, ext and pc registers.
// ----------------------------------------------------------------------------
// Sequence: mov, add, sub, jumps, prt, no-ops and divides by zero commit in
//   the execute state once the output register is free; mul, div and mod run
//   through start, DATA_WIDTH bit-serial steps, sign fix and commit.
// Requests: a new request is taken only after the previous one has committed.
// Reset: all four registers clear to zero and the output register empties.
module accumulator_machine_execute
  import ame_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic        source_is_register,
  input  logic [1:0]  source_register,
  input  logic [1:0]  target_register,
  input  logic signed [31:0] immediate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        print_valid,
  output logic signed [31:0] print_value,
  output logic        jump_taken,
  output logic signed [31:0] jump_offset,
  output logic        divide_fault
);

  state_t state;
  state_t state_next;

  // Architectural registers.
  logic [DATA_WIDTH-1:0] acc, acc_next;
  logic [DATA_WIDTH-1:0] dat, dat_next;
  logic [DATA_WIDTH-1:0] ext, ext_next;
  logic [DATA_WIDTH-1:0] pc,  pc_next;

  // Captured request.
  op_t                 op_q;
  logic                src_is_reg_q;
  reg_sel_t            src_sel_q;
  reg_sel_t            tgt_sel_q;
  logic signed [31:0]  imm_q;
  logic                neg_a_q;
  logic                neg_b_q;

  logic                  in_accept;
  logic                  slot_free;
  logic [DATA_WIDTH-1:0] imm_ext;
  logic [DATA_WIDTH-1:0] reg_rd;
  logic [DATA_WIDTH-1:0] src;
  logic                  is_muldiv;
  logic                  is_divmod;
  logic                  div_zero;
  logic                  a_neg;
  logic                  b_neg;
  logic                  jt;
  logic                  alu_sub;
  logic [DATA_WIDTH-1:0] alu_sum;
  logic [DATA_WIDTH-1:0] pc_base;
  logic [DATA_WIDTH-1:0] pc_sum;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic                  fix_neg;
  logic [DATA_WIDTH-1:0] fix_raw;
  logic [DATA_WIDTH-1:0] fix_val;
  logic                  commit_exec;
  logic                  commit_fix;
  md_ctl_t               md_ctl;
  md_sts_t               md_sts;
  logic [DATA_WIDTH-1:0] md_res;
  logic [DATA_WIDTH-1:0] md_quo;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // Operand selection from the register file or the immediate.
  assign imm_ext = DATA_WIDTH'(imm_q);

  always_comb begin
    case (src_sel_q)
      REG_ACC: reg_rd = acc;
      REG_DAT: reg_rd = dat;
      REG_EXT: reg_rd = ext;
      REG_PC:  reg_rd = pc;
      default: reg_rd = pc;
    endcase
  end

  assign src   = src_is_reg_q ? reg_rd : imm_ext;
  assign a_neg = acc[DATA_WIDTH-1];
  assign b_neg = src[DATA_WIDTH-1];

  // Decode and branch condition.
  always_comb begin
    is_muldiv = op_q inside {OP_MUL, OP_DIV, OP_MOD};
    is_divmod = op_q inside {OP_DIV, OP_MOD};
    div_zero  = is_divmod && (src == '0);
    case (op_q)
      OP_JMP:  jt = 1'b1;
      OP_JEQ:  jt = (acc == '0);
      OP_JLT:  jt = a_neg;
      OP_JGT:  jt = !a_neg && (acc != '0);
      default: jt = 1'b0;
    endcase
  end

  // Combinational arithmetic: add/sub, pc update and divide operand magnitudes.
  always_comb begin
    alu_sub = (op_q == OP_SUB);
    alu_sum = acc + (alu_sub ? ~src : src) + {{(DATA_WIDTH-1){1'b0}}, alu_sub};
    pc_base = (op_q == OP_MOV && tgt_sel_q == REG_PC) ? src : pc;
    pc_sum  = pc_base + (jt ? imm_ext : {{(DATA_WIDTH-1){1'b0}}, 1'b1});
    mag_a   = (is_divmod && a_neg) ? (~acc + 1'b1) : acc;
    mag_b   = (is_divmod && b_neg) ? (~src + 1'b1) : src;
  end

  // Sign correction of the multiply/divide result.
  always_comb begin
    case (op_q)
      OP_DIV: begin
        fix_neg = neg_a_q ^ neg_b_q;
        fix_raw = md_quo;
      end
      OP_MOD: begin
        fix_neg = neg_a_q;
        fix_raw = md_res;
      end
      default: begin
        fix_neg = 1'b0;
        fix_raw = md_res;
      end
    endcase
    fix_val = fix_neg ? (~fix_raw + 1'b1) : fix_raw;
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_muldiv && !div_zero) state_next = ST_WAIT;
        else if (slot_free)         state_next = ST_IDLE;
      end
      ST_WAIT: begin
        if (md_sts.done) state_next = ST_FIX;
      end
      ST_FIX: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit start and commit strobes.
  always_comb begin
    md_ctl.start  = 1'b0;
    md_ctl.divide = is_divmod;
    commit_exec   = 1'b0;
    commit_fix    = 1'b0;
    case (state)
      ST_EXEC: begin
        if (is_muldiv && !div_zero) md_ctl.start = 1'b1;
        else                        commit_exec  = slot_free;
      end
      ST_FIX:  commit_fix = slot_free;
      default: ;
    endcase
  end

  // Register file next values.
  always_comb begin
    acc_next = acc;
    dat_next = dat;
    ext_next = ext;
    pc_next  = pc;
    if (commit_exec) begin
      case (op_q)
        OP_MOV: begin
          case (tgt_sel_q)
            REG_ACC: acc_next = src;
            REG_DAT: dat_next = src;
            REG_EXT: ext_next = src;
            default: ;
          endcase
        end
        OP_ADD, OP_SUB: acc_next = alu_sum;
        default: ;
      endcase
      pc_next = pc_sum;
    end else if (commit_fix) begin
      acc_next = fix_val;
      pc_next  = pc_sum;
    end
  end

  // State and architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      acc   <= '0;
      dat   <= '0;
      ext   <= '0;
      pc    <= '0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      dat   <= dat_next;
      ext   <= ext_next;
      pc    <= pc_next;
    end
  end

  // Request capture and divide operand signs.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q         <= op_t'(opcode);
      src_is_reg_q <= source_is_register;
      src_sel_q    <= reg_sel_t'(source_register);
      tgt_sel_q    <= reg_sel_t'(target_register);
      imm_q        <= immediate;
    end
    if (md_ctl.start) begin
      neg_a_q <= a_neg;
      neg_b_q <= b_neg;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_exec || commit_fix) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (commit_exec || commit_fix) begin
      print_valid  <= (op_q == OP_PRT);
      print_value  <= (op_q == OP_PRT) ? 32'(src) : '0;
      jump_taken   <= jt;
      jump_offset  <= jt ? imm_q : OFFSET_NONE;
      divide_fault <= div_zero;
    end
  end

  // Shared multiply/divide unit.
  ame_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk (clk),
    .rst (rst),
    .ctl (md_ctl),
    .a   (mag_a),
    .b   (mag_b),
    .sts (md_sts),
    .res (md_res),
    .quo (md_quo)
  );

endmodule

// ===== src/ame_checker.sv =====
// ----------------------------------------------------------------------------
// Accumulator machine port checker
// Watches the execute stage's ports over time and is bound to the execute stage module.
// ----------------------------------------------------------------------------
module ame_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        print_valid,
  input logic signed [31:0] print_value,
  input logic        jump_taken,
  input logic signed [31:0] jump_offset,
  input logic        divide_fault
);

  // A result held under stall stays valid and keeps its print value and jump offset.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(print_value) && $stable(jump_offset))
    else $error("held result changed under stall");

  // One request is worked on at a time: an accepted request blocks the next.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

  // A result carries at most one of print, jump and divide fault.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({print_valid, jump_taken, divide_fault}) <= 1)
    else $error("result carries more than one event");

  // Inactive fields hold their idle values.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (print_valid || print_value == 0) && (jump_taken || jump_offset == 1))
    else $error("inactive result field not at idle value");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind accumulator_machine_execute ame_checker u_ame_checker (.*);

// ===== test/tb_accumulator_machine_execute.sv =====
// ----------------------------------------------------------------------------
// Accumulator machine execute stage testbench
// Drives instructions through the request channel and tracks the machine's
// registers in a scoreboard. Each result is checked field by field against
// the prediction. A directed sequence covers the corner cases. A long random
// run follows, with idle bursts on the request channel and stall bursts on the result channel.
// ----------------------------------------------------------------------------
module tb_accumulator_machine_execute;
  import ame_pkg::*;

  localparam int          RANDOM_REQUESTS = 2000;
  localparam int          QUIET_AFTER     = 1700;
  localparam int          DRAIN_CYCLES    = 40;
  localparam int          CYCLE_LIMIT     = 500000;
  localparam logic [3:0]  OP_NOP_FIRST    = 4'(OP_PRT) + 4'd1;
  localparam logic [3:0]  OP_NOP_LAST     = 4'hF;
  localparam logic [31:0] MOST_NEGATIVE   = 32'h8000_0000;
  localparam logic [31:0] MOST_POSITIVE   = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_ONE       = 32'hFFFF_FFFF;

  // One predicted result of an instruction.
  typedef struct {
    logic        print_valid;
    logic [31:0] print_value;
    logic        jump_taken;
    logic [31:0] jump_offset;
    logic        divide_fault;
  } exec_result_t;

  // Register-level model of the machine plus the queue of pending results.
  class exec_scoreboard;
    logic [31:0]  acc, dat, ext, pc;
    exec_result_t pending_results[$];
    int           errors;

    function new();
      acc = '0;
      dat = '0;
      ext = '0;
      pc = '0;
      errors = 0;
    endfunction

    function logic [31:0] read_reg(logic [1:0] sel);
      case (sel)
        REG_ACC: return acc;
        REG_DAT: return dat;
        REG_EXT: return ext;
        default: return pc;
      endcase
    endfunction

    function void write_reg(logic [1:0] sel, logic [31:0] value);
      case (sel)
        REG_ACC: acc = value;
        REG_DAT: dat = value;
        REG_EXT: ext = value;
        default: pc = value;
      endcase
    endfunction

    // Execute one accepted request on the model and queue its result.
    function void note_request(logic [3:0] op, logic sir, logic [1:0] sreg,
                               logic [1:0] treg, logic [31:0] imm);
      logic [31:0]  a, src, ua, ub, q, r;
      logic         taken;
      exec_result_t res;
      a = acc;
      src = sir ? read_reg(sreg) : imm;
      taken = 1'b0;
      res.print_valid = 1'b0;
      res.print_value = '0;
      res.divide_fault = 1'b0;
      case (op)
        OP_MOV: write_reg(treg, src);
        OP_ADD: acc = a + src;
        OP_SUB: acc = a - src;
        OP_MUL: acc = a * src;
        OP_DIV, OP_MOD: begin
          if (src == '0) begin
            res.divide_fault = 1'b1;
          end else begin
            // Work on magnitudes, then restore the signs; this truncates
            // toward zero and wraps the most negative value over minus one.
            ua = a[31] ? -a : a;
            ub = src[31] ? -src : src;
            q = ua / ub;
            r = ua % ub;
            if (op == OP_DIV) begin
              acc = (a[31] != src[31]) ? -q : q;
            end else begin
              acc = a[31] ? -r : r;
            end
          end
        end
        OP_JMP: taken = 1'b1;
        OP_JEQ: taken = (a == '0);
        OP_JLT: taken = a[31];
        OP_JGT: taken = (a != '0) && !a[31];
        OP_PRT: begin
          res.print_valid = 1'b1;
          res.print_value = src;
        end
        default: ;
      endcase
      // The program counter moves after the operands have been read.
      pc = taken ? pc + imm : pc + 32'd1;
      res.jump_taken = taken;
      res.jump_offset = taken ? imm : OFFSET_NONE;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] expected,
                                logic [31:0] actual);
      if (actual !== expected) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                 expected, actual);
        errors++;
      end
    endfunction

    // Compare one delivered result with the oldest prediction.
    function void check_result(logic pv, logic [31:0] pval, logic jt,
                               logic [31:0] joff, logic df);
      exec_result_t res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pv=%b jt=%b",
                 $time, pv, jt);
        errors++;
        return;
      end
      res = pending_results.pop_front();
      compare_field("print_valid", 32'(res.print_valid), 32'(pv));
      compare_field("print_value", res.print_value, pval);
      compare_field("jump_taken", 32'(res.jump_taken), 32'(jt));
      compare_field("jump_offset", res.jump_offset, joff);
      compare_field("divide_fault", 32'(res.divide_fault), 32'(df));
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         opcode = '0;
  logic               source_is_register = 1'b0;
  logic [1:0]         source_register = '0;
  logic [1:0]         target_register = '0;
  logic signed [31:0] immediate = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               print_valid;
  logic signed [31:0] print_value;
  logic               jump_taken;
  logic signed [31:0] jump_offset;
  logic               divide_fault;

  exec_scoreboard sb = new();
  bit             quiet = 1'b0;
  int             stall_left = 0;
  int             cycle_count = 0;

  accumulator_machine_execute i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .opcode             (opcode),
    .source_is_register (source_is_register),
    .source_register    (source_register),
    .target_register    (target_register),
    .immediate          (immediate),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .print_valid        (print_valid),
    .print_value        (print_value),
    .jump_taken         (jump_taken),
    .jump_offset        (jump_offset),
    .divide_fault       (divide_fault)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Global watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("accumulator_machine_execute verification failed");
      $finish;
    end
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every result accepted by the receiver.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(print_valid, print_value, jump_taken, jump_offset,
                      divide_fault);
    end
  end

  // Present one request and hold it until it is accepted.
  task automatic send_request(logic [3:0] op, logic sir, logic [1:0] sreg,
                              logic [1:0] treg, logic [31:0] imm);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    source_is_register <= sir;
    source_register <= sreg;
    target_register <= treg;
    immediate <= imm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, sir, sreg, treg, imm);
    @(negedge clk);
  endtask

  // Operand values biased toward small magnitudes and the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return 32'($urandom_range(0, 8));
      1: return -32'($urandom_range(1, 8));
      2: return MOST_NEGATIVE;
      3: return MOST_POSITIVE;
      4: return MINUS_ONE;
      default: return $urandom;
    endcase
  endfunction

  // Opcode mix weighted toward the instructions with the most behavior.
  function automatic logic [3:0] pick_opcode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 18) return OP_MOV;
    if (roll < 30) return ($urandom_range(0, 1) != 0) ? OP_ADD : OP_SUB;
    if (roll < 50) return 4'(OP_MUL) + 4'($urandom_range(0, 2));
    if (roll < 74) return 4'(OP_JMP) + 4'($urandom_range(0, 3));
    if (roll < 92) return OP_PRT;
    return 4'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
  endfunction

  initial begin
    logic [3:0] op;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corner cases.
    send_request(OP_MOV, 1'b0, REG_ACC, REG_ACC, MOST_POSITIVE);
    send_request(OP_ADD, 1'b0, REG_ACC, REG_ACC, 32'd1);        // wraps
    send_request(OP_MOV, 1'b1, REG_ACC, REG_DAT, 32'd0);
    send_request(OP_SUB, 1'b0, REG_ACC, REG_ACC, MOST_NEGATIVE);
    send_request(OP_JEQ, 1'b0, REG_ACC, REG_ACC, -32'd3);       // taken
    send_request(OP_JGT, 1'b0, REG_ACC, REG_ACC, 32'd9);        // not taken
    send_request(OP_JLT, 1'b0, REG_ACC, REG_ACC, 32'd9);        // not taken
    send_request(OP_MOV, 1'b0, REG_ACC, REG_ACC, -32'd7);
    send_request(OP_MOD, 1'b0, REG_ACC, REG_ACC, 32'd2);        // sign of dividend
    send_request(OP_JLT, 1'b0, REG_ACC, REG_ACC, 32'd0);        // taken, pc stays
    send_request(OP_MUL, 1'b0, REG_ACC, REG_ACC, MINUS_ONE);
    send_request(OP_JGT, 1'b1, REG_EXT, REG_ACC, 32'd5);        // register ignored
    send_request(OP_DIV, 1'b0, REG_ACC, REG_ACC, 32'd0);        // zero divisor
    send_request(OP_MOD, 1'b1, REG_EXT, REG_ACC, 32'd4);        // zero divisor
    send_request(OP_MOV, 1'b1, REG_DAT, REG_ACC, 32'd0);
    send_request(OP_DIV, 1'b0, REG_ACC, REG_ACC, MINUS_ONE);    // overflow wraps
    send_request(OP_MOD, 1'b0, REG_ACC, REG_ACC, MINUS_ONE);
    send_request(OP_JMP, 1'b1, REG_DAT, REG_ACC, MOST_NEGATIVE);
    send_request(OP_MOV, 1'b0, REG_ACC, REG_PC, MOST_POSITIVE);
    send_request(OP_PRT, 1'b1, REG_PC, REG_ACC, 32'd0);
    send_request(OP_PRT, 1'b0, REG_ACC, REG_ACC, MINUS_ONE);
    send_request(OP_MOV, 1'b1, REG_EXT, REG_EXT, 32'd0);        // onto itself
    send_request(OP_MOV, 1'b0, REG_ACC, REG_ACC, -32'd100);
    send_request(OP_DIV, 1'b0, REG_ACC, REG_ACC, 32'd7);
    for (int n = OP_NOP_FIRST; n <= OP_NOP_LAST; n++) begin
      send_request(4'(n), 1'b1, 2'(n), 2'(n), $urandom);
    end

    // Random instruction stream; idling and stalls stop for the final stretch.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == QUIET_AFTER) quiet = 1'b1;
      op = pick_opcode();
      send_request(op, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), pick_value());
    end
    in_valid <= 1'b0;

    // Drain, then allow the pipeline to settle.
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("accumulator_machine_execute verification clean");
    end else begin
      $display("accumulator_machine_execute verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ame_pkg.sv
src/ame_muldiv.sv
src/accumulator_machine_execute.sv
src/ame_checker.sv
test/tb_accumulator_machine_execute.sv
